// ===== src/false_color_palette_ramp_core_assert.svh =====
// Assertion macros for the false-colour palette ramp core.
// Included by the top level; needs nothing else.
`ifndef FALSE_COLOR_PALETTE_RAMP_CORE_ASSERT_SVH
`define FALSE_COLOR_PALETTE_RAMP_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FCPR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FCPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fcpr_pkg.sv =====
// Shared types, codes and segment tables of the false-colour palette ramp.
// No dependencies; imported by every other file but fcpr_div and the assertion header.
package fcpr_pkg;

  localparam int IDX_W     = 8;
  localparam int LEVEL_W   = 16;
  localparam int COUNT_W   = 9;
  localparam int CFG_IDX_W = 2;
  localparam int NUM_CH    = 3;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 16'hffff;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 2'd1;

  typedef enum logic [1:0] {
    PAL_GRAY,
    PAL_BLACKBODY,
    PAL_HEAT,
    PAL_RAINBOW
  } pal_t;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  // breakpoint codes and their positions in hundredths
  localparam int BP_NUM = 7;
  localparam logic [2:0] BP_P0   = 3'd0;
  localparam logic [2:0] BP_P25  = 3'd1;
  localparam logic [2:0] BP_P33  = 3'd2;
  localparam logic [2:0] BP_P50  = 3'd3;
  localparam logic [2:0] BP_P67  = 3'd4;
  localparam logic [2:0] BP_P75  = 3'd5;
  localparam logic [2:0] BP_P100 = 3'd6;

  // position times ceil(2**26 / 100): (n-1) * scale >> 26 is floor((n-1) * pct / 100),
  // exact while (n-1) * pct stays below 2**20
  localparam int BP_SHIFT   = 26;
  localparam int BP_SCALE_W = 27;
  localparam logic [BP_SCALE_W-1:0] BP_SCALE [BP_NUM] = '{
    27'd0, 27'd16777225, 27'd22145937, 27'd33554450, 27'd44962963, 27'd50331675,
    27'd67108900
  };

  // span codes: the breakpoint pairs that bound a segment
  localparam int SPAN_NUM = 10;
  localparam logic [3:0] SP_0_100  = 4'd0;
  localparam logic [3:0] SP_0_50   = 4'd1;
  localparam logic [3:0] SP_50_100 = 4'd2;
  localparam logic [3:0] SP_0_25   = 4'd3;
  localparam logic [3:0] SP_25_50  = 4'd4;
  localparam logic [3:0] SP_50_75  = 4'd5;
  localparam logic [3:0] SP_75_100 = 4'd6;
  localparam logic [3:0] SP_0_33   = 4'd7;
  localparam logic [3:0] SP_33_67  = 4'd8;
  localparam logic [3:0] SP_67_100 = 4'd9;
  localparam logic [2:0] SPAN_LO [SPAN_NUM] = '{BP_P0, BP_P0, BP_P50, BP_P0, BP_P25,
                                               BP_P50, BP_P75, BP_P0, BP_P33, BP_P67};
  localparam logic [2:0] SPAN_HI [SPAN_NUM] = '{BP_P100, BP_P50, BP_P100, BP_P25, BP_P50,
                                               BP_P75, BP_P100, BP_P33, BP_P67, BP_P100};

  // table build: one step per breakpoint, then one division per span
  localparam int STEP_NUM = BP_NUM + SPAN_NUM;
  localparam int STEP_W   = $clog2(STEP_NUM);

  typedef struct packed {
    pal_t       pal;
    logic [1:0] ch;
    logic [2:0] p0;
    logic       y0;
    logic [2:0] p1;
    logic       y1;
    logic [3:0] sp;
  } seg_t;

  localparam int SEG_NUM = 29;
  // within one palette and channel, a later entry wins where segments overlap
  localparam seg_t SEGS [SEG_NUM] = '{
    '{PAL_GRAY,      CH_RED,   BP_P0,   1'b0, BP_P100, 1'b1, SP_0_100},
    '{PAL_GRAY,      CH_GREEN, BP_P0,   1'b0, BP_P100, 1'b1, SP_0_100},
    '{PAL_GRAY,      CH_BLUE,  BP_P0,   1'b0, BP_P100, 1'b1, SP_0_100},
    '{PAL_BLACKBODY, CH_RED,   BP_P0,   1'b0, BP_P50,  1'b1, SP_0_50},
    '{PAL_BLACKBODY, CH_RED,   BP_P50,  1'b1, BP_P100, 1'b1, SP_50_100},
    '{PAL_BLACKBODY, CH_GREEN, BP_P0,   1'b0, BP_P25,  1'b0, SP_0_25},
    '{PAL_BLACKBODY, CH_GREEN, BP_P25,  1'b0, BP_P50,  1'b1, SP_25_50},
    '{PAL_BLACKBODY, CH_GREEN, BP_P50,  1'b1, BP_P100, 1'b1, SP_50_100},
    '{PAL_BLACKBODY, CH_BLUE,  BP_P0,   1'b0, BP_P50,  1'b0, SP_0_50},
    '{PAL_BLACKBODY, CH_BLUE,  BP_P50,  1'b0, BP_P100, 1'b1, SP_50_100},
    '{PAL_HEAT,      CH_RED,   BP_P0,   1'b0, BP_P25,  1'b0, SP_0_25},
    '{PAL_HEAT,      CH_RED,   BP_P25,  1'b0, BP_P50,  1'b1, SP_25_50},
    '{PAL_HEAT,      CH_RED,   BP_P50,  1'b1, BP_P100, 1'b1, SP_50_100},
    '{PAL_HEAT,      CH_GREEN, BP_P0,   1'b0, BP_P50,  1'b0, SP_0_50},
    '{PAL_HEAT,      CH_GREEN, BP_P50,  1'b0, BP_P75,  1'b1, SP_50_75},
    '{PAL_HEAT,      CH_GREEN, BP_P75,  1'b1, BP_P100, 1'b1, SP_75_100},
    '{PAL_HEAT,      CH_BLUE,  BP_P0,   1'b0, BP_P25,  1'b1, SP_0_25},
    '{PAL_HEAT,      CH_BLUE,  BP_P25,  1'b1, BP_P50,  1'b0, SP_25_50},
    '{PAL_HEAT,      CH_BLUE,  BP_P50,  1'b0, BP_P75,  1'b0, SP_50_75},
    '{PAL_HEAT,      CH_BLUE,  BP_P75,  1'b0, BP_P100, 1'b1, SP_75_100},
    '{PAL_RAINBOW,   CH_RED,   BP_P0,   1'b1, BP_P33,  1'b0, SP_0_33},
    '{PAL_RAINBOW,   CH_RED,   BP_P33,  1'b0, BP_P67,  1'b0, SP_33_67},
    '{PAL_RAINBOW,   CH_RED,   BP_P67,  1'b0, BP_P100, 1'b1, SP_67_100},
    '{PAL_RAINBOW,   CH_GREEN, BP_P0,   1'b0, BP_P33,  1'b1, SP_0_33},
    '{PAL_RAINBOW,   CH_GREEN, BP_P33,  1'b1, BP_P67,  1'b0, SP_33_67},
    '{PAL_RAINBOW,   CH_GREEN, BP_P67,  1'b0, BP_P100, 1'b0, SP_67_100},
    '{PAL_RAINBOW,   CH_BLUE,  BP_P0,   1'b0, BP_P33,  1'b0, SP_0_33},
    '{PAL_RAINBOW,   CH_BLUE,  BP_P33,  1'b0, BP_P67,  1'b1, SP_33_67},
    '{PAL_RAINBOW,   CH_BLUE,  BP_P67,  1'b1, BP_P100, 1'b0, SP_67_100}
  };

  typedef enum logic [1:0] {
    MODE_LOW,
    MODE_HIGH,
    MODE_UP,
    MODE_DOWN
  } mode_t;

  typedef enum logic [1:0] {
    SEQ_LOAD,
    SEQ_WAIT,
    SEQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic busy;
    pal_t palette;
  } cfg_stat_t;

  function automatic mode_t seg_mode(input logic y0, input logic y1);
    mode_t m;
    unique case ({y0, y1})
      2'b00:   m = MODE_LOW;
      2'b11:   m = MODE_HIGH;
      2'b01:   m = MODE_UP;
      default: m = MODE_DOWN;
    endcase
    return m;
  endfunction

endpackage

// ===== src/fcpr_if.sv =====
// Channel interfaces of the false-colour palette ramp: index in, colour out, config.
// Depends on fcpr_pkg for the field widths.
interface fcpr_in_if import fcpr_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] color_index;

  modport source (output valid, color_index, input ready);
  modport sink (input valid, color_index, output ready);
endinterface

interface fcpr_out_if import fcpr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] red;
  logic [LEVEL_W-1:0] green;
  logic [LEVEL_W-1:0] blue;
  logic               out_of_range;

  modport source (output valid, red, green, blue, out_of_range, input ready);
  modport sink (input valid, red, green, blue, out_of_range, output ready);
endinterface

interface fcpr_cfg_if import fcpr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [COUNT_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/fcpr_div.sv =====
// Restoring divider, one quotient bit per cycle, for the ramp table build.
// Depends on nothing but its parameter.
module fcpr_div #(
  parameter int DIV_W = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             running;
  logic [CNT_W-1:0] cnt;
  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quo;
  logic [DIV_W-1:0] dsr;
  logic [DIV_W:0]   trial;
  logic             ge;
  logic [DIV_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo[DIV_W-1]};
    ge       = trial >= {1'b0, dsr};
    rem_next = ge ? DIV_W'(trial - {1'b0, dsr}) : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (running) begin
      rem <= rem_next;
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

  assign quotient = quo;

endmodule

// ===== src/fcpr_cfg.sv =====
// Configuration registers and ramp table build: breakpoints and slopes per span.
// Depends on fcpr_pkg, fcpr_if and fcpr_div.
module fcpr_cfg import fcpr_pkg::*; #(
  parameter int MAX_COLOR_COUNT = 256
) (
  input  logic                                            clk,
  input  logic                                            rst,
  fcpr_cfg_if.sink                                        cfg,
  output cfg_stat_t                                       stat,
  output logic [$clog2(MAX_COLOR_COUNT+1)-1:0]            count_eff,
  output logic [BP_NUM-1:0][$clog2(MAX_COLOR_COUNT)-1:0]  bp,
  output logic [SPAN_NUM-1:0][LEVEL_W-1:0]                slope
);

  localparam int CNT_W   = $clog2(MAX_COLOR_COUNT + 1);
  localparam int BP_W    = $clog2(MAX_COLOR_COUNT);
  localparam int RCP_W   = BP_W + BP_SCALE_W;
  localparam int DIV_W   = LEVEL_W;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEP_NUM - 1);
  localparam logic [STEP_W-1:0] STEP_SPAN = STEP_W'(BP_NUM);

  pal_t               palette;
  logic [COUNT_W-1:0] color_count;
  seq_state_t         state;
  seq_state_t         state_next;
  logic [STEP_W-1:0]  step;

  logic                                count_wr;
  logic [CNT_W-1:0]                    n;
  logic [BP_W-1:0]                     nm1;
  logic [SPAN_NUM-1:0][BP_W-1:0]       span;
  logic                                is_bp_step;
  logic [2:0]                          bp_idx;
  logic [3:0]                          span_idx;
  logic [BP_W-1:0]                     span_cur;
  logic [RCP_W-1:0]                    bp_rcp;
  logic [BP_W-1:0]                     bp_quo;
  logic [DIV_W-1:0]                    dividend;
  logic [DIV_W-1:0]                    divisor;
  logic                                div_start;
  logic                                div_done;
  logic [DIV_W-1:0]                    quotient;

  assign cfg.ready = 1'b1;
  assign count_wr  = cfg.valid && (cfg.index == REG_COLOR_COUNT);

  // saturate the count; an empty palette still needs sane breakpoints
  always_comb begin
    if (32'(color_count) > 32'(MAX_COLOR_COUNT)) n = CNT_W'(MAX_COLOR_COUNT);
    else n = CNT_W'(color_count);
    nm1 = (n == '0) ? '0 : BP_W'(n - 1'b1);
  end

  always_comb begin
    for (int s = 0; s < SPAN_NUM; s++) begin
      span[s] = bp[SPAN_HI[s]] - bp[SPAN_LO[s]];
    end
  end

  // breakpoints by reciprocal multiply, one per cycle; slopes on the divider
  always_comb begin
    is_bp_step = step < STEP_SPAN;
    bp_idx     = is_bp_step ? step[2:0] : BP_P0;
    span_idx   = is_bp_step ? SP_0_100 : 4'(step - STEP_SPAN);
    span_cur   = span[span_idx];
    bp_rcp     = RCP_W'(nm1) * RCP_W'(BP_SCALE[bp_idx]);
    bp_quo     = BP_W'(bp_rcp >> BP_SHIFT);
    dividend   = DIV_W'(LEVEL_MAX);
    divisor    = DIV_W'(span_cur);
  end

  fcpr_div #(.DIV_W(DIV_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    if (count_wr) begin
      state_next = SEQ_LOAD;
    end else begin
      unique case (state)
        SEQ_LOAD: begin
          if (!is_bp_step) begin
            div_start  = 1'b1;
            state_next = SEQ_WAIT;
          end
        end
        SEQ_WAIT: begin
          if (div_done) state_next = (step == STEP_LAST) ? SEQ_DONE : SEQ_LOAD;
        end
        SEQ_DONE: state_next = SEQ_DONE;
        default:  state_next = SEQ_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= SEQ_LOAD;
      step        <= '0;
      palette     <= PAL_GRAY;
      color_count <= COUNT_RESET;
    end else begin
      state <= state_next;
      if (cfg.valid && cfg.index == REG_PALETTE) palette <= pal_t'(cfg.data[1:0]);
      if (count_wr) color_count <= cfg.data;
      if (count_wr) begin
        step <= '0;
      end else if (state == SEQ_LOAD && is_bp_step) begin
        step <= step + 1'b1;
      end else if (state == SEQ_WAIT && div_done && step != STEP_LAST) begin
        step <= step + 1'b1;
      end
    end
  end

  // empty span: flat slope
  always_ff @(posedge clk) begin
    if (!count_wr) begin
      if (state == SEQ_LOAD && is_bp_step) bp[bp_idx] <= bp_quo;
      if (state == SEQ_WAIT && div_done && !is_bp_step)
        slope[span_idx] <= (span_cur == '0) ? '0 : quotient[LEVEL_W-1:0];
    end
  end

  assign stat.busy    = state != SEQ_DONE;
  assign stat.palette = palette;
  assign count_eff    = n;

endmodule

// ===== src/fcpr_pipe.sv =====
// Three-stage colour pipeline: segment select, slope multiply, level form.
// Depends on fcpr_pkg and fcpr_if; tables come from fcpr_cfg.
module fcpr_pipe import fcpr_pkg::*; #(
  parameter int MAX_COLOR_COUNT = 256
) (
  input  logic                                            clk,
  input  logic                                            rst,
  fcpr_in_if.sink                                         pixel,
  fcpr_out_if.source                                      color,
  input  cfg_stat_t                                       stat,
  input  logic [$clog2(MAX_COLOR_COUNT+1)-1:0]            count_eff,
  input  logic [BP_NUM-1:0][$clog2(MAX_COLOR_COUNT)-1:0]  bp,
  input  logic [SPAN_NUM-1:0][LEVEL_W-1:0]                slope
);

  localparam int CNT_W  = $clog2(MAX_COLOR_COUNT + 1);
  localparam int BP_W   = $clog2(MAX_COLOR_COUNT);
  localparam int CMP_W  = (CNT_W > IDX_W) ? CNT_W : IDX_W;
  localparam int PROD_W = LEVEL_W + IDX_W;

  logic adv;
  logic take;
  logic v1, v2, v3;

  // stage 1 select
  logic [CMP_W-1:0]  idx_w;
  logic [BP_W-1:0]   sel_a    [NUM_CH];
  mode_t             sel_mode [NUM_CH];
  logic [LEVEL_W-1:0] sel_q   [NUM_CH];
  logic              s1_oor;
  mode_t             s1_mode  [NUM_CH];
  logic [LEVEL_W-1:0] s1_q    [NUM_CH];
  logic [IDX_W-1:0]  s1_d     [NUM_CH];

  // stage 2 multiply
  logic [PROD_W-1:0]  prod    [NUM_CH];
  logic               s2_oor;
  mode_t              s2_mode [NUM_CH];
  logic [LEVEL_W-1:0] s2_prod [NUM_CH];

  // stage 3 level
  logic [LEVEL_W-1:0] level   [NUM_CH];
  logic [LEVEL_W-1:0] s3_level [NUM_CH];
  logic               s3_oor;

  // whole pipe holds while the output register is full and not taken
  assign adv         = !v3 || color.ready;
  assign pixel.ready = adv && !stat.busy;
  assign take        = pixel.valid && pixel.ready;

  always_comb begin
    idx_w = CMP_W'(pixel.color_index);
    for (int c = 0; c < NUM_CH; c++) begin
      sel_a[c]    = '0;
      sel_mode[c] = MODE_LOW;
      sel_q[c]    = '0;
      for (int k = 0; k < SEG_NUM; k++) begin
        if (SEGS[k].ch == 2'(c) && SEGS[k].pal == stat.palette &&
            idx_w >= CMP_W'(bp[SEGS[k].p0]) && idx_w <= CMP_W'(bp[SEGS[k].p1])) begin
          sel_a[c]    = bp[SEGS[k].p0];
          sel_mode[c] = seg_mode(SEGS[k].y0, SEGS[k].y1);
          sel_q[c]    = slope[SEGS[k].sp];
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      prod[c] = PROD_W'(s1_q[c]) * PROD_W'(s1_d[c]);
    end
  end

  // slope times offset never exceeds full scale inside a segment
  always_comb begin
    for (int c = 0; c < NUM_CH; c++) begin
      level[c] = '0;
      if (!s2_oor) begin
        unique case (s2_mode[c])
          MODE_LOW:  level[c] = '0;
          MODE_HIGH: level[c] = LEVEL_MAX;
          MODE_UP:   level[c] = s2_prod[c];
          MODE_DOWN: level[c] = LEVEL_MAX - s2_prod[c];
          default:   level[c] = '0;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_oor <= idx_w >= CMP_W'(count_eff);
      s2_oor <= s1_oor;
      s3_oor <= s2_oor;
      for (int c = 0; c < NUM_CH; c++) begin
        s1_mode[c]  <= sel_mode[c];
        s1_q[c]     <= sel_q[c];
        s1_d[c]     <= IDX_W'(idx_w - CMP_W'(sel_a[c]));
        s2_mode[c]  <= s1_mode[c];
        s2_prod[c]  <= prod[c][LEVEL_W-1:0];
        s3_level[c] <= level[c];
      end
    end
  end

  assign color.valid        = v3;
  assign color.red          = s3_level[0];
  assign color.green        = s3_level[1];
  assign color.blue         = s3_level[2];
  assign color.out_of_range = s3_oor;

endmodule

// ===== src/false_color_palette_ramp_core.sv =====
// False-colour palette ramp core: colour index in, 16-bit RGB out.
// Channels: pixel carries color_index; color returns red, green, blue and
// out_of_range; cfg writes palette (index 0) and color_count (index 1).
// Each transfer on pixel gives exactly one transfer on color, in order.
// A result passes the select, multiply and level stages, the last of which is
// the output register. Throughput: one index per cycle once the ramp tables are
// built and while color.ready does not hold the pipe.
// Table build: 7 breakpoints by reciprocal multiply, one per cycle, then
// 10 slopes one after another on one bit-serial divider.
// It runs after reset and after every color_count write; pixel.ready stays low
// meanwhile, cfg writes are always taken. Reset selects grayscale over 256 colours.
// When color.ready is low with a result waiting, all stages hold and
// pixel.ready drops in the same cycle; nothing is lost or repeated.
// Indexes at or above the colour count return zero colour with out_of_range.
// Depends on fcpr_pkg, fcpr_if, fcpr_cfg, fcpr_pipe and the assertion header.
`include "false_color_palette_ramp_core_assert.svh"

module false_color_palette_ramp_core import fcpr_pkg::*; #(
  parameter int MAX_COLOR_COUNT = 256
) (
  input  logic        clk,
  input  logic        rst,
  fcpr_in_if.sink     pixel,
  fcpr_out_if.source  color,
  fcpr_cfg_if.sink    cfg
);

  localparam int CNT_W = $clog2(MAX_COLOR_COUNT + 1);
  localparam int BP_W  = $clog2(MAX_COLOR_COUNT);

  cfg_stat_t                         stat;
  logic [CNT_W-1:0]                  count_eff;
  logic [BP_NUM-1:0][BP_W-1:0]       bp;
  logic [SPAN_NUM-1:0][LEVEL_W-1:0]  slope;
  logic                              count_wr;

  fcpr_cfg #(.MAX_COLOR_COUNT(MAX_COLOR_COUNT)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .stat      (stat),
    .count_eff (count_eff),
    .bp        (bp),
    .slope     (slope)
  );

  fcpr_pipe #(.MAX_COLOR_COUNT(MAX_COLOR_COUNT)) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .pixel     (pixel),
    .color     (color),
    .stat      (stat),
    .count_eff (count_eff),
    .bp        (bp),
    .slope     (slope)
  );

  assign count_wr = cfg.valid && cfg.ready && (cfg.index == REG_COLOR_COUNT);

  `FCPR_ASSERT_SAME(a_oor_zero, clk, rst, color.valid && color.out_of_range, color.red == '0 && color.green == '0 && color.blue == '0, "out-of-range result carries colour")
  `FCPR_ASSERT_NEXT(a_count_wr_blocks, clk, rst, count_wr, !pixel.ready, "index taken during table rebuild")
  `FCPR_ASSERT_SAME(a_rebuild_cause, clk, rst, $rose(stat.busy), $past(count_wr), "table rebuild without count write")

endmodule

// ===== tb/sv/false_color_palette_ramp_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench of the false-colour palette ramp core: directed and random index streams
// under every palette and many colour counts, checked against an in-bench colour predictor.
// Depends on fcpr_pkg, the channel interfaces in fcpr_if and the core itself.
module false_color_palette_ramp_core_tb;
  import fcpr_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 6;
  localparam int IDLE_PCT      = 14;
  localparam int DRAIN_SLACK   = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 1650;
  localparam int BURST_ITEMS   = 250;
  localparam int PCT_SCALE     = 100;
  localparam int COUNT_LIMIT   = 256;
  localparam int PRINT_LIMIT   = 40;

  // indexes the core does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    pal_t       pal;
    logic [1:0] chan;
    logic [6:0] lo_pct;
    logic       lo_full;
    logic [6:0] hi_pct;
    logic       hi_full;
  } ramp_seg_t;

  // ramp segments per palette and channel; a later entry wins where two overlap
  localparam ramp_seg_t RAMP_SEGS [29] = '{
    '{PAL_GRAY,      CH_RED,   7'd0,  1'b0, 7'd100, 1'b1},
    '{PAL_GRAY,      CH_GREEN, 7'd0,  1'b0, 7'd100, 1'b1},
    '{PAL_GRAY,      CH_BLUE,  7'd0,  1'b0, 7'd100, 1'b1},
    '{PAL_BLACKBODY, CH_RED,   7'd0,  1'b0, 7'd50,  1'b1},
    '{PAL_BLACKBODY, CH_RED,   7'd50, 1'b1, 7'd100, 1'b1},
    '{PAL_BLACKBODY, CH_GREEN, 7'd0,  1'b0, 7'd25,  1'b0},
    '{PAL_BLACKBODY, CH_GREEN, 7'd25, 1'b0, 7'd50,  1'b1},
    '{PAL_BLACKBODY, CH_GREEN, 7'd50, 1'b1, 7'd100, 1'b1},
    '{PAL_BLACKBODY, CH_BLUE,  7'd0,  1'b0, 7'd50,  1'b0},
    '{PAL_BLACKBODY, CH_BLUE,  7'd50, 1'b0, 7'd100, 1'b1},
    '{PAL_HEAT,      CH_RED,   7'd0,  1'b0, 7'd25,  1'b0},
    '{PAL_HEAT,      CH_RED,   7'd25, 1'b0, 7'd50,  1'b1},
    '{PAL_HEAT,      CH_RED,   7'd50, 1'b1, 7'd100, 1'b1},
    '{PAL_HEAT,      CH_GREEN, 7'd0,  1'b0, 7'd50,  1'b0},
    '{PAL_HEAT,      CH_GREEN, 7'd50, 1'b0, 7'd75,  1'b1},
    '{PAL_HEAT,      CH_GREEN, 7'd75, 1'b1, 7'd100, 1'b1},
    '{PAL_HEAT,      CH_BLUE,  7'd0,  1'b0, 7'd25,  1'b1},
    '{PAL_HEAT,      CH_BLUE,  7'd25, 1'b1, 7'd50,  1'b0},
    '{PAL_HEAT,      CH_BLUE,  7'd50, 1'b0, 7'd75,  1'b0},
    '{PAL_HEAT,      CH_BLUE,  7'd75, 1'b0, 7'd100, 1'b1},
    '{PAL_RAINBOW,   CH_RED,   7'd0,  1'b1, 7'd33,  1'b0},
    '{PAL_RAINBOW,   CH_RED,   7'd33, 1'b0, 7'd67,  1'b0},
    '{PAL_RAINBOW,   CH_RED,   7'd67, 1'b0, 7'd100, 1'b1},
    '{PAL_RAINBOW,   CH_GREEN, 7'd0,  1'b0, 7'd33,  1'b1},
    '{PAL_RAINBOW,   CH_GREEN, 7'd33, 1'b1, 7'd67,  1'b0},
    '{PAL_RAINBOW,   CH_GREEN, 7'd67, 1'b0, 7'd100, 1'b0},
    '{PAL_RAINBOW,   CH_BLUE,  7'd0,  1'b0, 7'd33,  1'b0},
    '{PAL_RAINBOW,   CH_BLUE,  7'd33, 1'b0, 7'd67,  1'b1},
    '{PAL_RAINBOW,   CH_BLUE,  7'd67, 1'b1, 7'd100, 1'b0}
  };

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic               out_of_range;
  } rgb_result_t;

  logic clk;
  logic rst;

  fcpr_in_if  pixel_ch ();
  fcpr_out_if color_ch ();
  fcpr_cfg_if cfg_ch ();

  false_color_palette_ramp_core dut (
    .clk   (clk),
    .rst   (rst),
    .pixel (pixel_ch),
    .color (color_ch),
    .cfg   (cfg_ch)
  );

  pal_t               cur_palette;
  logic [COUNT_W-1:0] cur_count;
  rgb_result_t        pending_colors [$];
  int                 mismatches;
  int                 indexes_sent;
  int                 cycles;
  bit                 no_idle;

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    color_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("mismatch at cycle %0d, %0s: got %h, want %h", cycles, what, got, want);
  endtask

  function automatic logic [LEVEL_W-1:0] channel_level(input pal_t pal, input logic [1:0] chan,
                                                       input int n, input int idx);
    int lo, hi, y_lo, y_hi, slope, level;
    level = 0;
    foreach (RAMP_SEGS[k]) begin
      if (RAMP_SEGS[k].pal == pal && RAMP_SEGS[k].chan == chan) begin
        lo    = ((n - 1) * int'(RAMP_SEGS[k].lo_pct)) / PCT_SCALE;
        hi    = ((n - 1) * int'(RAMP_SEGS[k].hi_pct)) / PCT_SCALE;
        y_lo  = RAMP_SEGS[k].lo_full ? int'(LEVEL_MAX) : 0;
        y_hi  = RAMP_SEGS[k].hi_full ? int'(LEVEL_MAX) : 0;
        // integer slope truncated toward zero, flat on an empty span
        slope = (lo == hi) ? 0 : (y_hi - y_lo) / (hi - lo);
        if (idx >= lo && idx <= hi)
          level = y_lo + slope * (idx - lo);
      end
    end
    return level[LEVEL_W-1:0];
  endfunction

  function automatic rgb_result_t ramp_color(input logic [IDX_W-1:0] idx);
    rgb_result_t res;
    int n;
    n = (cur_count > COUNT_LIMIT) ? COUNT_LIMIT : int'(cur_count);
    res = '0;
    if (int'(idx) >= n) begin
      res.out_of_range = 1'b1;
    end else begin
      res.red   = channel_level(cur_palette, CH_RED, n, idx);
      res.green = channel_level(cur_palette, CH_GREEN, n, idx);
      res.blue  = channel_level(cur_palette, CH_BLUE, n, idx);
    end
    return res;
  endfunction

  // entered and left just after a falling edge; valid stays high on return
  task automatic send_index(input logic [IDX_W-1:0] idx);
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        pixel_ch.valid <= 1'b0;
        @(negedge clk);
      end
    end
    pixel_ch.valid       <= 1'b1;
    pixel_ch.color_index <= idx;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
    pending_colors.push_back(ramp_color(idx));
    indexes_sent++;
    @(negedge clk);
  endtask

  // drop valid and hold until every expected colour has come back
  task automatic wait_colors_drained();
    pixel_ch.valid <= 1'b0;
    while (pending_colors.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_PALETTE)
      cur_palette = pal_t'(data[1:0]);
    else if (idx == REG_COLOR_COUNT)
      cur_count = data;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // palette data carries random upper bits, which the core must ignore
  task automatic set_palette(input pal_t pal);
    logic [COUNT_W-1:0] data;
    data      = COUNT_W'($urandom);
    data[1:0] = pal;
    write_cfg(REG_PALETTE, data);
  endtask

  task automatic set_ramp(input pal_t pal, input int count);
    wait_colors_drained();
    set_palette(pal);
    write_cfg(REG_COLOR_COUNT, COUNT_W'(count));
  endtask

  task automatic test_reset_state();
    send_index(8'd0);
    send_index(8'd255);
  endtask

  task automatic test_palette_extremes();
    pal_t pal;
    for (int p = int'(PAL_BLACKBODY); p <= int'(PAL_RAINBOW); p++) begin
      pal = pal_t'(p);
      set_ramp(pal, COUNT_LIMIT);
      send_index(8'd0);
      send_index(8'd64);
      send_index(8'd128);
      send_index(8'd255);
    end
  endtask

  task automatic test_count_edges();
    // a single colour: every breakpoint collapses onto index zero
    set_ramp(PAL_RAINBOW, 1);
    send_index(8'd0);
    send_index(8'd1);
    // zero colours: everything is out of range
    set_ramp(PAL_HEAT, 0);
    send_index(8'd0);
    // counts above the limit saturate
    set_ramp(PAL_GRAY, 511);
    send_index(8'd255);
    set_ramp(PAL_BLACKBODY, 2);
    send_index(8'd0);
    send_index(8'd1);
    send_index(8'd2);
    // writes to undecoded indexes leave the setting alone
    wait_colors_drained();
    write_cfg(REG_SPARE_2, COUNT_W'($urandom));
    write_cfg(REG_SPARE_3, COUNT_W'($urandom));
    set_ramp(PAL_HEAT, 100);
    send_index(8'd99);
    send_index(8'd100);
  endtask

  task automatic test_random_sweep();
    int target, batch, n, pick;
    target = indexes_sent + RANDOM_ITEMS;
    while (indexes_sent < target) begin
      wait_colors_drained();
      set_palette(pal_t'($urandom_range(3)));
      // leave the count alone now and then, so no table rebuild follows
      if ($urandom_range(99) >= 30) begin
        pick = $urandom_range(99);
        if (pick < 8)       n = 1;
        else if (pick < 16) n = COUNT_LIMIT;
        else if (pick < 20) n = 0;
        else if (pick < 26) n = $urandom_range(511, COUNT_LIMIT + 1);
        else if (pick < 32) n = 2;
        else                n = $urandom_range(COUNT_LIMIT - 1, 3);
        write_cfg(REG_COLOR_COUNT, COUNT_W'(n));
      end
      n = (cur_count > COUNT_LIMIT) ? COUNT_LIMIT : int'(cur_count);
      batch = $urandom_range(90, 30);
      for (int i = 0; i < batch; i++) begin
        if (n > 0 && $urandom_range(99) < 85)
          send_index(IDX_W'($urandom_range(n - 1, 0)));
        else
          send_index(IDX_W'($urandom_range(255, 0)));
        if (i == batch / 2 && $urandom_range(9) == 0)
          wait_colors_drained();
      end
    end
  endtask

  task automatic test_back_to_back();
    set_ramp(PAL_HEAT, COUNT_LIMIT);
    no_idle = 1'b1;
    for (int i = 0; i < BURST_ITEMS; i++)
      send_index(IDX_W'($urandom));
    wait_colors_drained();
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin : check_colors
    rgb_result_t want;
    if (!rst && color_ch.valid && color_ch.ready) begin
      if (pending_colors.size() == 0) begin
        report_mismatch("colour with nothing pending", color_ch.red, 0);
      end else begin
        want = pending_colors.pop_front();
        if (color_ch.red !== want.red)
          report_mismatch("red", color_ch.red, want.red);
        if (color_ch.green !== want.green)
          report_mismatch("green", color_ch.green, want.green);
        if (color_ch.blue !== want.blue)
          report_mismatch("blue", color_ch.blue, want.blue);
        if (color_ch.out_of_range !== want.out_of_range)
          report_mismatch("out_of_range", color_ch.out_of_range, want.out_of_range);
      end
    end
  end

  initial begin
    clk                  = 1'b0;
    rst                  = 1'b1;
    pixel_ch.valid       = 1'b0;
    pixel_ch.color_index = '0;
    color_ch.ready       = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = REG_PALETTE;
    cfg_ch.data          = '0;
    cur_palette          = PAL_GRAY;
    cur_count            = COUNT_RESET;
    mismatches           = 0;
    indexes_sent         = 0;
    cycles               = 0;
    no_idle              = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_state();
    test_palette_extremes();
    test_count_edges();
    test_random_sweep();
    test_back_to_back();
    wait_colors_drained();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/fcpr_pkg.sv
src/fcpr_if.sv
src/fcpr_div.sv
src/fcpr_cfg.sv
src/fcpr_pipe.sv
src/false_color_palette_ramp_core.sv
tb/sv/false_color_palette_ramp_core_tb.sv
